// ----- rtl/hart_frame_parser_unit_assert.svh -----
// Assertion macros for the frame parser.
// Depends on a clock named clk and a synchronous reset named rst in the including scope.
`ifndef HART_FRAME_PARSER_UNIT_ASSERT_SVH
`define HART_FRAME_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define HFP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define HFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Implication that is also checked while reset is high.
`define HFP_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

// ----- rtl/hfp_pkg.sv -----
// Shared types and constants of the frame parser.
// No dependencies.
`default_nettype none

package hfp_pkg;

  // Frame byte codes.
  localparam logic [7:0] PREAMBLE_BYTE = 8'hFF;
  localparam logic [7:0] START_SHORT   = 8'h82;
  localparam logic [7:0] START_LONG    = 8'h06;

  // Saturation limits of the frame counters.
  localparam logic [4:0] PRE_SAT  = 5'd31;
  localparam logic [2:0] HPOS_SAT = 3'd7;
  localparam logic [2:0] FLC_SAT  = 3'd5;

  // Header byte positions counted after the start byte.
  localparam logic [2:0] ADDR_POS       = 3'd0;
  localparam logic [2:0] CMD_POS_SHORT  = 3'd1;
  localparam logic [2:0] CMD_POS_LONG   = 3'd5;
  localparam logic [2:0] CNT_POS_SHORT  = 3'd2;
  localparam logic [2:0] CNT_POS_LONG   = 3'd6;
  localparam logic [2:0] NEED_SHORT     = 3'd4;
  localparam logic [2:0] NEED_LONG      = 3'd7;

  // Summary status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_NO_START  = 3'd2;
  localparam logic [2:0] ST_BAD_START = 3'd3;
  localparam logic [2:0] ST_TRUNC     = 3'd4;

  // Result kinds.
  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Queue between the front and back parts.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // One queue entry: the results caused by one accepted byte.
  typedef struct packed {
    logic       has_data;
    logic       has_sum;
    logic [7:0] data_byte;
    logic [7:0] data_index;
    logic [7:0] address;
    logic [7:0] command;
    logic [7:0] byte_count;
    logic       long_frame;
    logic [2:0] status;
    logic       preamble_ok;
    logic       checksum_ok;
  } hfp_entry_t;

  // Handshake between the queue and its neighbors.
  typedef struct packed {
    logic valid;
    logic space;
  } hfp_qstat_t;

endpackage

`default_nettype wire

// ----- rtl/hfp_if.sv -----
// Channel interfaces of the frame parser: input bytes, results and configuration.
// No dependencies.
`default_nettype none

interface hfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;
  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface hfp_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  logic [7:0] data_index;
  logic [7:0] address;
  logic [7:0] command;
  logic [7:0] byte_count;
  logic [2:0] status;
  logic       long_frame;
  logic       preamble_ok;
  logic       checksum_ok;
  logic       last;
  modport source (output valid, output kind, output data_byte, output data_index,
                  output address, output command, output byte_count, output status,
                  output long_frame, output preamble_ok, output checksum_ok,
                  output last, input ready);
  modport sink (input valid, input kind, input data_byte, input data_index,
                input address, input command, input byte_count, input status,
                input long_frame, input preamble_ok, input checksum_ok,
                input last, output ready);
endinterface

interface hfp_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] min_preamble;
  modport source (output valid, output min_preamble, input ready);
  modport sink (input valid, input min_preamble, output ready);
endinterface

`default_nettype wire

// ----- rtl/hart_frame_parser_unit.sv -----
// Top level of the frame parser: configuration register, front, queue and back parts.
// Depends on hfp_pkg, the hfp interfaces, hfp_front, hfp_queue, hfp_back and the assert macros.
//
//  Channel  Direction  Payload
//  frame    in         frame_byte[7:0], last_byte
//  result   out        kind, data_byte, data_index, address, command, byte_count,
//                      status[2:0], long_frame, preamble_ok, checksum_ok, last
//  cfg      in         min_preamble[4:0]
//
// One frame byte is accepted per cycle; its frame state is registered as it is accepted.
// A byte yields at most a data result and a summary; the back part sends one result per
// cycle while result.ready is high, so a final byte that also carries data holds the output for both results.
// A four-entry queue between front and back absorbs output stalls; input stalls only
// when it is full. Reset is synchronous; min_preamble resets to 5, and no clearing pass
// is needed. Configuration writes are taken at once.
`default_nettype none

`include "hart_frame_parser_unit_assert.svh"

module hart_frame_parser_unit
  import hfp_pkg::*;
#(
  parameter int PAYLOAD_CAPACITY = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  hfp_in_if.sink    frame,
  hfp_out_if.source result,
  hfp_cfg_if.sink   cfg
);

  logic [4:0] min_preamble;
  logic       push;
  logic       pop;
  hfp_entry_t wr_entry;
  hfp_entry_t rd_entry;
  hfp_qstat_t qstat;

  // Configuration register.
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      min_preamble <= 5'd5;
    end else if (cfg.valid && cfg.ready) begin
      min_preamble <= cfg.min_preamble;
    end
  end

  hfp_front #(
    .PAYLOAD_CAPACITY(PAYLOAD_CAPACITY)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .frame        (frame),
    .min_preamble (min_preamble),
    .qstat        (qstat),
    .push         (push),
    .entry        (wr_entry)
  );

  hfp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .rd_entry (rd_entry),
    .qstat    (qstat)
  );

  hfp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .qstat   (qstat),
    .q_entry (rd_entry),
    .pop     (pop),
    .result  (result)
  );

  // A summary always closes the results of its byte.
  `HFP_ASSERT_NOW(a_sum_last, result.valid && result.kind == KIND_SUMMARY, result.last, "summary without last")

  // Data results carry no summary flags.
  `HFP_ASSERT_NOW(a_data_clean, result.valid && result.kind == KIND_DATA, result.status == ST_OK && !result.preamble_ok && !result.checksum_ok, "data result with summary fields")

  // An entry popped from the queue always shows up as a result in the next cycle.
  `HFP_ASSERT_NEXT(a_pop_shows, pop, result.valid, "popped entry not presented")

  // Nothing is presented directly after reset.
  `HFP_ASSERT_ALWAYS(a_reset_idle, $past(rst), !result.valid, "result valid after reset")

endmodule

`default_nettype wire

// ----- rtl/hfp_front.sv -----
// Front part: accepts frame bytes, tracks the frame state and builds queue entries.
// Depends on hfp_pkg and hfp_in_if.
`default_nettype none

module hfp_front
  import hfp_pkg::*;
#(
  parameter int PAYLOAD_CAPACITY = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  hfp_in_if.sink          frame,
  input  wire logic [4:0] min_preamble,
  input  wire hfp_qstat_t qstat,
  output logic            push,
  output hfp_entry_t      entry
);

  typedef enum logic [1:0] {PH_PRE, PH_HDR, PH_DATA, PH_BAD} phase_t;

  localparam logic [7:0] CAP = 8'(PAYLOAD_CAPACITY);

  phase_t     phase, phase_next;
  logic [4:0] pre_cnt, pre_cnt_next;
  logic [2:0] hpos, hpos_next;
  logic [2:0] flc, flc_next;
  logic [7:0] xsum, xsum_next;
  logic [7:0] addr, addr_next;
  logic [7:0] cmd, cmd_next;
  logic [7:0] bcnt, bcnt_next;
  logic [7:0] dcnt, dcnt_next;
  logic       long_flag, long_next;

  logic       accept;
  logic       fin;
  logic [7:0] b;
  logic [7:0] lim;
  logic       emit;
  logic [2:0] need;
  logic [2:0] st;

  assign frame.ready = qstat.space;
  assign accept      = frame.valid && frame.ready;
  assign b           = frame.frame_byte;
  assign fin         = frame.last_byte;
  assign lim         = (bcnt < CAP) ? bcnt : CAP;
  assign emit        = (phase == PH_DATA) && (dcnt < lim);

  // Next frame state for the byte at the input.
  always_comb begin
    phase_next   = phase;
    pre_cnt_next = pre_cnt;
    hpos_next    = hpos;
    flc_next     = (flc < FLC_SAT) ? flc + 3'd1 : flc;
    xsum_next    = xsum ^ b;
    addr_next    = addr;
    cmd_next     = cmd;
    bcnt_next    = bcnt;
    dcnt_next    = dcnt;
    long_next    = long_flag;
    case (phase)
      PH_PRE: begin
        xsum_next = xsum;
        if (b == PREAMBLE_BYTE) begin
          if (pre_cnt < PRE_SAT) pre_cnt_next = pre_cnt + 5'd1;
        end else begin
          xsum_next = b;
          if (b == START_SHORT) begin
            long_next  = 1'b0;
            phase_next = PH_HDR;
          end else if (b == START_LONG) begin
            long_next  = 1'b1;
            phase_next = PH_HDR;
          end else begin
            phase_next = PH_BAD;
          end
        end
      end
      PH_HDR: begin
        if (hpos == ADDR_POS) addr_next = b;
        if (hpos == (long_flag ? CMD_POS_LONG : CMD_POS_SHORT)) cmd_next = b;
        if (hpos == (long_flag ? CNT_POS_LONG : CNT_POS_SHORT)) begin
          bcnt_next  = b;
          phase_next = PH_DATA;
        end
        if (hpos < HPOS_SAT) hpos_next = hpos + 3'd1;
      end
      PH_DATA: begin
        if (hpos < HPOS_SAT) hpos_next = hpos + 3'd1;
        if (emit) dcnt_next = dcnt + 8'd1;
      end
      default: begin
      end
    endcase
  end

  // Summary status, in priority order.
  assign need = long_next ? NEED_LONG : NEED_SHORT;
  always_comb begin
    if (flc_next < FLC_SAT) st = ST_SHORT;
    else if (phase_next == PH_PRE) st = ST_NO_START;
    else if (phase_next == PH_BAD) st = ST_BAD_START;
    else if (hpos_next < need) st = ST_TRUNC;
    else st = ST_OK;
  end

  // Queue entry for the results of this byte.
  assign push = accept && (emit || fin);
  always_comb begin
    entry.has_data    = emit;
    entry.has_sum     = fin;
    entry.data_byte   = b;
    entry.data_index  = dcnt;
    entry.address     = addr_next;
    entry.command     = cmd_next;
    entry.byte_count  = bcnt_next;
    entry.long_frame  = long_next;
    entry.status      = st;
    entry.preamble_ok = (pre_cnt_next >= min_preamble);
    entry.checksum_ok = (phase_next != PH_PRE) && (xsum_next == 8'd0);
  end

  // Frame state; the final byte returns it to the start of a frame.
  always_ff @(posedge clk) begin
    if (rst || (accept && fin)) begin
      phase     <= PH_PRE;
      pre_cnt   <= '0;
      hpos      <= '0;
      flc       <= '0;
      xsum      <= '0;
      addr      <= '0;
      cmd       <= '0;
      bcnt      <= '0;
      dcnt      <= '0;
      long_flag <= 1'b0;
    end else if (accept) begin
      phase     <= phase_next;
      pre_cnt   <= pre_cnt_next;
      hpos      <= hpos_next;
      flc       <= flc_next;
      xsum      <= xsum_next;
      addr      <= addr_next;
      cmd       <= cmd_next;
      bcnt      <= bcnt_next;
      dcnt      <= dcnt_next;
      long_flag <= long_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/hfp_queue.sv -----
// Short queue of result entries between the front and back parts.
// Depends on hfp_pkg.
`default_nettype none

module hfp_queue
  import hfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire hfp_entry_t wr_entry,
  input  wire logic       pop,
  output hfp_entry_t      rd_entry,
  output hfp_qstat_t      qstat
);

  hfp_entry_t              mem [QDEPTH];
  logic [QPTR_W-1:0]       wptr;
  logic [QPTR_W-1:0]       rptr;
  logic [QCNT_W-1:0]       count;

  assign qstat.valid = (count != '0);
  assign qstat.space = (count != QCNT_W'(QDEPTH));
  assign rd_entry    = mem[rptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wr_entry;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + QPTR_W'(1);
      if (pop) rptr <= rptr + QPTR_W'(1);
      if (push && !pop) count <= count + QCNT_W'(1);
      else if (pop && !push) count <= count - QCNT_W'(1);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/hfp_back.sv -----
// Back part: takes queue entries and delivers their data and summary results.
// Depends on hfp_pkg and hfp_out_if.
`default_nettype none

module hfp_back
  import hfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire hfp_qstat_t qstat,
  input  wire hfp_entry_t q_entry,
  output logic            pop,
  hfp_out_if.source       result
);

  hfp_entry_t cur;
  logic       pend_data;
  logic       pend_sum;
  logic       fire;
  logic       finishing;

  assign result.valid = pend_data || pend_sum;
  assign fire         = result.valid && result.ready;
  assign finishing    = fire && !(pend_data && pend_sum);
  assign pop          = qstat.valid && (!result.valid || finishing);

  // Result fields: the data result goes out before the summary.
  always_comb begin
    result.address    = cur.address;
    result.command    = cur.command;
    result.byte_count = cur.byte_count;
    result.long_frame = cur.long_frame;
    if (pend_data) begin
      result.kind        = KIND_DATA;
      result.data_byte   = cur.data_byte;
      result.data_index  = cur.data_index;
      result.status      = ST_OK;
      result.preamble_ok = 1'b0;
      result.checksum_ok = 1'b0;
      result.last        = !pend_sum;
    end else begin
      result.kind        = KIND_SUMMARY;
      result.data_byte   = 8'd0;
      result.data_index  = 8'd0;
      result.status      = cur.status;
      result.preamble_ok = cur.preamble_ok;
      result.checksum_ok = cur.checksum_ok;
      result.last        = 1'b1;
    end
  end

  // Output register and pending flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_data <= 1'b0;
      pend_sum  <= 1'b0;
    end else if (pop) begin
      cur       <= q_entry;
      pend_data <= q_entry.has_data;
      pend_sum  <= q_entry.has_sum;
    end else if (fire) begin
      if (pend_data) pend_data <= 1'b0;
      else pend_sum <= 1'b0;
    end
  end

endmodule

`default_nettype wire
